### design/ctr_pkg.sv
`timescale 1ns / 1ps
// ctr_pkg: shared types, widths and the mixed quotient/remainder adder
// for the catmull-rom tessellator; used by every module of the block

package ctr_pkg;

  // field widths
  localparam int COORD_W = 32;
  localparam int RES_W = 7;
  localparam int MAX_RES_DEF = 64;
  localparam int COORD_BITS_DEF = 32;

  // internal widths, sized for the largest resolution of 64
  localparam int COEF_W = 40;   // spline coefficients a, b, c
  localparam int DIVN_W = 48;   // forward differences before division
  localparam int REM_W = 20;    // divisor 2*r^3 and remainders
  localparam int Q_W = 56;      // quotients
  localparam int R2_W = 13;     // r*r
  localparam int R3_W = 19;     // r*r*r
  localparam int JOBQ_DEPTH = 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [2:0] vec_t;   // index 0 x, 1 y, 2 z

  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    logic   restart;
  } point_in_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
    logic   last_of_segment;
  } point_out_t;

  // one segment: four control points (index 0 oldest) and the resolution
  typedef struct packed {
    vec_t [3:0]       pts;
    logic [RES_W-1:0] res;
  } job_t;

  // value held as quotient and remainder of a division by 2*r^3
  typedef struct packed {
    logic signed [Q_W-1:0] q;
    logic [REM_W-1:0]      r;
  } mix_t;

  // divider status seen by the top level
  typedef struct packed {
    logic done_any;
    logic done_all;
  } back_stat_t;

  // add two mixed values, carrying the remainder into the quotient
  function automatic mix_t mix_add(mix_t a, mix_t b, logic [REM_W-1:0] d);
    logic [REM_W:0] s;
    logic ge;
    mix_t o;
    s = {1'b0, a.r} + {1'b0, b.r};
    ge = (s >= {1'b0, d});
    o.r = ge ? REM_W'(s - {1'b0, d}) : s[REM_W-1:0];
    o.q = a.q + b.q + {{(Q_W-1){1'b0}}, ge};
    return o;
  endfunction

endpackage

### design/ctr_front.sv
`timescale 1ns / 1ps
// ctr_front: accepts control points, keeps the three-point window and
// hands complete segments to the job queue; depends on ctr_pkg

module ctr_front #(
  parameter int MAX_RESOLUTION = ctr_pkg::MAX_RES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  ctr_pkg::point_in_t        point,
  input  logic [ctr_pkg::RES_W-1:0] resolution,
  output logic                      jq_push,
  output ctr_pkg::job_t             jq_data,
  input  logic                      jq_full
);

  logic                      accept;
  logic [1:0]                cnt;
  logic [1:0]                eff_cnt;
  ctr_pkg::vec_t [2:0]       win;
  ctr_pkg::vec_t             newpt;
  logic [ctr_pkg::RES_W-1:0] rclamp;

  // input word handshake
  assign full    = jq_full;
  assign accept  = push && !jq_full;
  assign eff_cnt = point.restart ? 2'd0 : cnt;
  assign newpt   = {point.pos_z, point.pos_y, point.pos_x};

  // effective resolution
  always_comb begin
    if (resolution == '0) begin
      rclamp = ctr_pkg::RES_W'(1);
    end else if (resolution > ctr_pkg::RES_W'(MAX_RESOLUTION)) begin
      rclamp = ctr_pkg::RES_W'(MAX_RESOLUTION);
    end else begin
      rclamp = resolution;
    end
  end

  // segment job
  assign jq_push     = accept && (eff_cnt == 2'd3);
  assign jq_data.pts = {newpt, win[2], win[1], win[0]};
  assign jq_data.res = rclamp;

  // window fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (accept && eff_cnt != 2'd3) begin
      cnt <= eff_cnt + 2'd1;
    end
  end

  // window points
  always_ff @(posedge clk) begin
    if (accept) begin
      if (eff_cnt != 2'd3) begin
        win[eff_cnt] <= newpt;
      end else begin
        win[0] <= win[1];
        win[1] <= win[2];
        win[2] <= newpt;
      end
    end
  end

endmodule

### design/ctr_jobq.sv
`timescale 1ns / 1ps
// ctr_jobq: short register queue of segment jobs between front and back
// depends on ctr_pkg

module ctr_jobq (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  ctr_pkg::job_t wdata,
  output logic          full,
  input  logic          rd,
  output ctr_pkg::job_t rdata,
  output logic          empty
);

  localparam int PW = (ctr_pkg::JOBQ_DEPTH > 1) ? $clog2(ctr_pkg::JOBQ_DEPTH) : 1;
  localparam int CW = $clog2(ctr_pkg::JOBQ_DEPTH + 1);

  ctr_pkg::job_t mem [ctr_pkg::JOBQ_DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] cnt;
  logic          do_wr;
  logic          do_rd;

  assign full  = (cnt == CW'(ctr_pkg::JOBQ_DEPTH));
  assign empty = (cnt == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rp];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_wr) begin
        wp <= (wp == PW'(ctr_pkg::JOBQ_DEPTH - 1)) ? '0 : wp + PW'(1);
      end
      if (do_rd) begin
        rp <= (rp == PW'(ctr_pkg::JOBQ_DEPTH - 1)) ? '0 : rp + PW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt <= cnt + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  // entries
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp] <= wdata;
    end
  end

endmodule

### design/ctr_fdiv.sv
`timescale 1ns / 1ps
// ctr_fdiv: bit-serial floor division of a signed value by 2*r^3,
// one quotient bit per cycle, remainder kept non-negative; depends on ctr_pkg

module ctr_fdiv (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [ctr_pkg::DIVN_W-1:0]  x,
  input  logic [ctr_pkg::REM_W-1:0]          d,
  output logic                               done,
  output logic signed [ctr_pkg::Q_W-1:0]     q,
  output logic [ctr_pkg::REM_W-1:0]          r
);

  localparam int N  = ctr_pkg::DIVN_W;
  localparam int RW = ctr_pkg::REM_W;
  localparam int CW = $clog2(N);

  logic            busy;
  logic            neg;
  logic [N-1:0]    acc;
  logic [RW-1:0]   rem;
  logic [RW-1:0]   dvr;
  logic [CW-1:0]   cnt;
  logic [RW:0]     shifted;
  logic            ge;
  logic [ctr_pkg::Q_W-1:0] uq;
  logic            nz;

  // restoring step
  assign shifted = {rem, acc[N-1]};
  assign ge      = (shifted >= {1'b0, dvr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && cnt == CW'(N - 1)) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= x[N-1];
      acc <= x[N-1] ? N'(-x) : N'(x);
      rem <= '0;
      dvr <= d;
      cnt <= '0;
    end else if (busy) begin
      rem <= ge ? RW'(shifted - {1'b0, dvr}) : shifted[RW-1:0];
      acc <= {acc[N-2:0], ge};
      cnt <= cnt + CW'(1);
    end
  end

  // sign fixup toward floor
  assign uq = {{(ctr_pkg::Q_W - N){1'b0}}, acc};
  assign nz = (rem != '0);
  assign q  = neg ? (nz ? ~uq : -uq) : uq;
  assign r  = (neg && nz) ? dvr - rem : rem;

endmodule

### design/ctr_back.sv
`timescale 1ns / 1ps
// ctr_back: sets up one segment's forward differences, divides them with
// ctr_fdiv lanes, steps out a curve point a cycle unless stalled; uses ctr_pkg

module ctr_back #(
  parameter int COORD_BITS = ctr_pkg::COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctr_pkg::job_t        jq_data,
  input  logic                 jq_empty,
  output logic                 jq_pop,
  output logic                 empty,
  input  logic                 pop,
  output ctr_pkg::point_out_t  result,
  output ctr_pkg::back_stat_t  stat
);

  localparam int CF = ctr_pkg::COEF_W;
  localparam int DN = ctr_pkg::DIVN_W;
  localparam int QW = ctr_pkg::Q_W;
  localparam int RW = ctr_pkg::REM_W;
  localparam int RSW = ctr_pkg::RES_W;
  localparam logic signed [QW-1:0] SAT_HI = (QW'(1) <<< (COORD_BITS - 1)) - QW'(1);
  localparam logic signed [QW-1:0] SAT_LO = -SAT_HI - QW'(1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_COEF = 6'b000010,
    S_MUL  = 6'b000100,
    S_SUM  = 6'b001000,
    S_DIV  = 6'b010000,
    S_STEP = 6'b100000
  } state_t;

  state_t state;
  ctr_pkg::job_t job;
  logic [RSW-1:0] rv;
  logic [RSW-1:0] idx;
  logic [ctr_pkg::R2_W-1:0] r2;
  logic [ctr_pkg::R3_W-1:0] r3;
  logic [RW-1:0] dd;
  logic signed [CF-1:0] ca [3];
  logic signed [CF-1:0] cb [3];
  logic signed [CF-1:0] cc [3];
  logic signed [DN-1:0] ar2 [3];
  logic signed [DN-1:0] br [3];
  logic signed [DN-1:0] c6 [3];
  logic signed [DN-1:0] dvd [3][3];
  logic div_start;
  logic [8:0] dn_vec;
  logic signed [QW-1:0] dq [3][3];
  logic [RW-1:0] dr [3][3];
  ctr_pkg::mix_t v [3];
  ctr_pkg::mix_t d1 [3];
  ctr_pkg::mix_t d2 [3];
  ctr_pkg::mix_t d3 [3];
  ctr_pkg::mix_t nv [3];
  ctr_pkg::mix_t nd1 [3];
  ctr_pkg::mix_t nd2 [3];
  logic signed [CF-1:0] pe [4][3];
  logic ov;
  logic adv;
  logic div_ready;

  function automatic ctr_pkg::coord_t sat(logic signed [QW-1:0] a);
    logic signed [QW-1:0] s;
    s = (a > SAT_HI) ? SAT_HI : (a < SAT_LO) ? SAT_LO : a;
    return s[ctr_pkg::COORD_W-1:0];
  endfunction

  assign jq_pop    = (state == S_IDLE) && !jq_empty;
  assign adv       = (state == S_STEP) && (!ov || pop);
  assign div_ready = (dn_vec == '1) && !div_start;
  assign empty     = !ov;
  assign stat.done_any = (dn_vec != '0);
  assign stat.done_all = (dn_vec == '1);

  // control points widened for coefficient sums
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int a = 0; a < 3; a++) begin
        pe[k][a] = CF'(job.pts[k][a]);
      end
    end
  end

  // next step of the forward differences
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      nv[a]  = ctr_pkg::mix_add(v[a], d1[a], dd);
      nd1[a] = ctr_pkg::mix_add(d1[a], d2[a], dd);
      nd2[a] = ctr_pkg::mix_add(d2[a], d3[a], dd);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!jq_empty) begin
            state <= S_COEF;
          end
        end
        S_COEF: state <= S_MUL;
        S_MUL:  state <= S_SUM;
        S_SUM: begin
          state     <= S_DIV;
          div_start <= 1'b1;
        end
        S_DIV: begin
          if (div_ready) begin
            state <= S_STEP;
          end
        end
        S_STEP: begin
          if (adv && idx == rv) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (adv) begin
      ov <= 1'b1;
    end else if (pop) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.out_x           <= sat(nv[0].q);
      result.out_y           <= sat(nv[1].q);
      result.out_z           <= sat(nv[2].q);
      result.last_of_segment <= (idx == rv);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (!jq_empty) begin
          job <= jq_data;
          rv  <= jq_data.res;
        end
      end
      S_COEF: begin
        r2 <= ctr_pkg::R2_W'(rv) * ctr_pkg::R2_W'(rv);
        for (int a = 0; a < 3; a++) begin
          ca[a] <= pe[2][a] - pe[0][a];
          cb[a] <= (pe[0][a] <<< 1) - (pe[1][a] <<< 2) - pe[1][a]
                   + (pe[2][a] <<< 2) - pe[3][a];
          cc[a] <= (pe[1][a] <<< 1) + pe[1][a] - pe[0][a]
                   - (pe[2][a] <<< 1) - pe[2][a] + pe[3][a];
        end
      end
      S_MUL: begin
        r3 <= ctr_pkg::R3_W'(r2) * ctr_pkg::R3_W'(rv);
        dd <= RW'(r2) * RW'({rv, 1'b0});
        for (int a = 0; a < 3; a++) begin
          ar2[a] <= DN'(ca[a]) * $signed(DN'({1'b0, r2}));
          br[a]  <= DN'(cb[a]) * $signed(DN'({1'b0, rv}));
          c6[a]  <= (DN'(cc[a]) <<< 2) + (DN'(cc[a]) <<< 1);
        end
      end
      S_SUM: begin
        for (int a = 0; a < 3; a++) begin
          dvd[a][0] <= ar2[a] + br[a] + DN'(cc[a]);
          dvd[a][1] <= (br[a] <<< 1) + c6[a];
          dvd[a][2] <= c6[a];
        end
      end
      S_DIV: begin
        idx <= RSW'(1);
        for (int a = 0; a < 3; a++) begin
          v[a].q  <= QW'(job.pts[1][a]);
          v[a].r  <= RW'(r3);
          d1[a].q <= dq[a][0];
          d1[a].r <= dr[a][0];
          d2[a].q <= dq[a][1];
          d2[a].r <= dr[a][1];
          d3[a].q <= dq[a][2];
          d3[a].r <= dr[a][2];
        end
      end
      S_STEP: begin
        if (adv) begin
          idx <= idx + RSW'(1);
          for (int a = 0; a < 3; a++) begin
            v[a]  <= nv[a];
            d1[a] <= nd1[a];
            d2[a] <= nd2[a];
          end
        end
      end
      default: begin
      end
    endcase
  end

  // division lanes: three differences for each axis
  for (genvar a = 0; a < 3; a++) begin : g_axis
    for (genvar k = 0; k < 3; k++) begin : g_diff
      ctr_fdiv u_div (
        .clk   (clk),
        .rst   (rst),
        .start (div_start),
        .x     (dvd[a][k]),
        .d     (dd),
        .done  (dn_vec[a * 3 + k]),
        .q     (dq[a][k]),
        .r     (dr[a][k])
      );
    end
  end

endmodule

### design/catmull_rom_tessellator.sv
`timescale 1ns / 1ps
// catmull_rom_tessellator: top level, resolution register, front, job
// queue and back; depends on ctr_pkg, ctr_front, ctr_jobq and ctr_back

// Uniform Catmull-Rom tessellator. Control points (signed Q15.16) are
// pushed one per word; the first three fill the window and give no output,
// each later point emits `resolution` curve points (0 taken as 1, capped at
// MAX_RESOLUTION) of the segment between the middle two window points, the
// last one flagged, and restart empties the window before its point enters.
// In the back end a segment passes through taking the job, coefficient
// set-up, the divide state (start, the steps of the bit-serial dividers that
// turn the forward differences into quotient and remainder form, and the
// hand-over), then one curve point per cycle while the output is not
// stalled. A two-entry job queue lets the front keep accepting points while
// the back works. The user must write the resolution register only while
// the block is idle; the block itself does not enforce this.

module catmull_rom_tessellator #(
  parameter int MAX_RESOLUTION = ctr_pkg::MAX_RES_DEF,
  parameter int COORD_BITS     = ctr_pkg::COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  ctr_pkg::point_in_t        point,
  output logic                      empty,
  input  logic                      pop,
  output ctr_pkg::point_out_t       result,
  input  logic                      cfg_we,
  input  logic [ctr_pkg::RES_W-1:0] cfg_data
);

  logic [ctr_pkg::RES_W-1:0] resolution;
  logic                      jq_push;
  logic                      jq_full;
  logic                      jq_pop;
  logic                      jq_empty;
  ctr_pkg::job_t             jq_wdata;
  ctr_pkg::job_t             jq_rdata;
  ctr_pkg::back_stat_t       bstat;

  // resolution register
  always_ff @(posedge clk) begin
    if (rst) begin
      resolution <= ctr_pkg::RES_W'(16);
    end else if (cfg_we) begin
      resolution <= cfg_data;
    end
  end

  // point window and segment classification
  ctr_front #(
    .MAX_RESOLUTION (MAX_RESOLUTION)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .point      (point),
    .resolution (resolution),
    .jq_push    (jq_push),
    .jq_data    (jq_wdata),
    .jq_full    (jq_full)
  );

  // segment queue
  ctr_jobq u_jobq (
    .clk   (clk),
    .rst   (rst),
    .wr    (jq_push),
    .wdata (jq_wdata),
    .full  (jq_full),
    .rd    (jq_pop),
    .rdata (jq_rdata),
    .empty (jq_empty)
  );

  // segment evaluation
  ctr_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .jq_data  (jq_rdata),
    .jq_empty (jq_empty),
    .jq_pop   (jq_pop),
    .empty    (empty),
    .pop      (pop),
    .result   (result),
    .stat     (bstat)
  );

`ifndef SYNTHESIS
  // all division lanes start together and must finish together
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    bstat.done_any |-> bstat.done_all)
    else $error("division lanes out of step");

  // a segment job never meets a full queue
  a_jobq_room: assert property (@(posedge clk) disable iff (rst)
    jq_push |-> !jq_full)
    else $error("segment job pushed into full queue");

  // the back only takes a job that is present
  a_jobq_pop: assert property (@(posedge clk) disable iff (rst)
    jq_pop |-> !jq_empty)
    else $error("segment job taken from empty queue");
`endif

endmodule

### sim/ctr_checker.sv
`timescale 1ns / 1ps
// ctr_checker: watches the point, result and resolution ports of the
// catmull-rom tessellator, predicts each curve point and compares; uses ctr_pkg

module ctr_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic                      full,
  input  ctr_pkg::point_in_t        point,
  input  logic                      empty,
  input  logic                      pop,
  input  ctr_pkg::point_out_t       result,
  input  logic                      cfg_we,
  input  logic [ctr_pkg::RES_W-1:0] cfg_data,
  output int                        errors,
  output int                        pending,
  output int                        seen_words
);

  localparam int MAX_RES = 64;

  logic [ctr_pkg::RES_W-1:0] res_reg;
  ctr_pkg::coord_t           win [0:2][0:2];   // [point][axis], point 0 oldest
  int                        win_cnt;
  ctr_pkg::point_out_t       exp_q[$];

  // one coordinate of the uniform spline, rounded half up and saturated
  function automatic ctr_pkg::coord_t spline_coord(longint p0, longint p1, longint p2,
                                                   longint p3, longint i, longint r);
    longint a, b, c, r3, num, q;
    a = p2 - p0;
    b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    c = -p0 + 3 * p1 - 3 * p2 + p3;
    r3 = r * r * r;
    num = 2 * p1 * r3 + a * i * r * r + b * i * i * r + c * i * i * i + r3;
    q = num / (2 * r3);
    if ((num % (2 * r3)) != 0 && num < 0) q = q - 1;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return ctr_pkg::coord_t'(q);
  endfunction

  // take one control point, queue the curve points it causes
  task automatic predict_point(ctr_pkg::point_in_t p);
    ctr_pkg::coord_t     nw [0:2];
    longint              r;
    ctr_pkg::point_out_t o;
    ctr_pkg::coord_t     v [0:2];
    nw[0] = p.pos_x; nw[1] = p.pos_y; nw[2] = p.pos_z;
    if (p.restart) win_cnt = 0;
    if (win_cnt < 3) begin
      for (int d = 0; d < 3; d++) win[win_cnt][d] = nw[d];
      win_cnt++;
      return;
    end
    r = res_reg;
    if (r < 1) r = 1;
    if (r > MAX_RES) r = MAX_RES;
    for (longint i = 1; i <= r; i++) begin
      for (int d = 0; d < 3; d++)
        v[d] = spline_coord(win[0][d], win[1][d], win[2][d], nw[d], i, r);
      o.out_x = v[0];
      o.out_y = v[1];
      o.out_z = v[2];
      o.last_of_segment = (i == r);
      exp_q = {exp_q, o};
    end
    for (int d = 0; d < 3; d++) begin
      win[0][d] = win[1][d];
      win[1][d] = win[2][d];
      win[2][d] = nw[d];
    end
  endtask

  // compare one accepted word with the oldest expected point
  task automatic check_word(ctr_pkg::point_out_t got);
    ctr_pkg::point_out_t want;
    seen_words++;
    if (exp_q.size() == 0) begin
      $display("%0t: unexpected word %h", $time, got);
      errors++;
      return;
    end
    want = exp_q[0];
    exp_q.delete(0);
    if (got.out_x !== want.out_x) begin
      $display("%0t: out_x expected %h actual %h", $time, want.out_x, got.out_x);
      errors++;
    end
    if (got.out_y !== want.out_y) begin
      $display("%0t: out_y expected %h actual %h", $time, want.out_y, got.out_y);
      errors++;
    end
    if (got.out_z !== want.out_z) begin
      $display("%0t: out_z expected %h actual %h", $time, want.out_z, got.out_z);
      errors++;
    end
    if (got.last_of_segment !== want.last_of_segment) begin
      $display("%0t: last_of_segment expected %b actual %b", $time,
               want.last_of_segment, got.last_of_segment);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    seen_words = 0;
    pending = 0;
    win_cnt = 0;
    res_reg = 7'd16;
  end

  // track the channels at each edge
  always @(posedge clk) begin
    if (rst) begin
      res_reg = 7'd16;
      win_cnt = 0;
      exp_q.delete();
    end else begin
      if (cfg_we) res_reg = cfg_data;
      if (push && !full) predict_point(point);
      if (pop && !empty) check_word(result);
    end
    pending = exp_q.size();
  end

  // final leftovers are reported by the top through pending
endmodule

### sim/tb_catmull_rom_tessellator.sv
`timescale 1ns / 1ps
// tb_catmull_rom_tessellator: stimulus, idling and verdict for the
// tessellator; depends on ctr_pkg, catmull_rom_tessellator and ctr_checker

module tb_catmull_rom_tessellator;

  logic                      clk;
  logic                      rst;
  logic                      push;
  logic                      full;
  ctr_pkg::point_in_t        point;
  logic                      empty;
  logic                      pop;
  ctr_pkg::point_out_t       result;
  logic                      cfg_we;
  logic [ctr_pkg::RES_W-1:0] cfg_data;
  int                        errors;
  int                        pending;
  int                        seen_words;

  int                        idle_pct;
  int                        stall_pct;
  logic                      hold_go;
  logic                      hold_done;
  int                        hold_left;
  int                        sent;

  catmull_rom_tessellator u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .point(point),
    .empty(empty), .pop(pop), .result(result),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  ctr_checker u_chk (
    .clk(clk), .rst(rst), .push(push), .full(full), .point(point),
    .empty(empty), .pop(pop), .result(result),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .seen_words(seen_words)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // receiver: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_left <= 400;
      hold_done <= 1'b1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // one coordinate: full range, small values or extremes
  function automatic ctr_pkg::coord_t rand_coord();
    int unsigned k;
    k = $urandom_range(9);
    if (k < 3) return ctr_pkg::coord_t'($urandom);
    if (k < 9) return ctr_pkg::coord_t'($signed($urandom_range(2097152)) - 1048576);
    return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
  endfunction

  // offer one point, leaving push high after acceptance
  task automatic send_point(ctr_pkg::coord_t x, ctr_pkg::coord_t y, ctr_pkg::coord_t z,
                            logic rs);
    if ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    push <= 1'b1;
    point <= '{pos_x: x, pos_y: y, pos_z: z, restart: rs};
    do @(posedge clk); while (full);
    sent++;
  endtask

  // drain, let the back settle, then write the resolution
  task automatic set_resolution(logic [ctr_pkg::RES_W-1:0] v);
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(logic [ctr_pkg::RES_W-1:0] v, int idl, int stl, int n);
    set_resolution(v);
    idle_pct = idl;
    stall_pct = stl;
    for (int k = 0; k < n; k++)
      send_point(rand_coord(), rand_coord(), rand_coord(),
                 ($urandom_range(19) == 0));
  endtask

  localparam ctr_pkg::coord_t CMAX = 32'sh7fffffff;
  localparam ctr_pkg::coord_t CMIN = 32'sh80000000;

  initial begin
    rst = 1'b1;
    push = 1'b0;
    point = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_go = 1'b0;
    sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset resolution, extremes, saturation both ways
    send_point(0, 0, 0, 1'b1);
    send_point(CMAX, CMIN, CMAX, 1'b0);
    send_point(CMIN, CMAX, CMIN, 1'b0);
    send_point(CMAX, CMIN, CMAX, 1'b0);
    send_point(CMIN, CMAX, CMIN, 1'b0);
    send_point(32'sh00010000, -32'sh00010000, 32'sh7fff0000, 1'b0);
    // restart while the window is full, then while still filling
    send_point(1, 2, 3, 1'b1);
    send_point(-1, -2, -3, 1'b0);
    send_point(5, 6, 7, 1'b1);
    send_point(CMAX, CMAX, CMAX, 1'b0);
    send_point(CMAX, CMAX, CMAX, 1'b0);
    send_point(CMAX, CMAX, CMAX, 1'b0);
    send_point(-32'sh12345, 32'sh54321, 32'sh0, 1'b0);

    // resolution one, zero (as one) and above the limit (as the limit)
    set_resolution(7'd1);
    send_point(CMIN, CMIN, CMIN, 1'b0);
    send_point(32'sh00008000, -32'sh00008000, 1, 1'b0);
    set_resolution(7'd0);
    send_point(-1, 1, 0, 1'b0);
    send_point(CMAX, 0, CMIN, 1'b0);
    set_resolution(7'd127);
    send_point(7, -7, 7, 1'b0);
    set_resolution(7'd64);
    send_point(CMIN, CMAX, 0, 1'b0);

    // random phases across settings and idling styles
    random_phase(7'd16, 0, 0, 70);
    random_phase(7'd2, 49, 0, 60);
    random_phase(7'd64, 0, 49, 12);
    random_phase(7'd0, 36, 36, 40);
    // long receiver hold-off while points keep coming
    set_resolution(7'd3);
    idle_pct = 0;
    stall_pct = 0;
    hold_go <= 1'b1;
    for (int k = 0; k < 60; k++)
      send_point(rand_coord(), rand_coord(), rand_coord(), ($urandom_range(19) == 0));
    random_phase(7'd127, 36, 36, 8);
    random_phase(7'($urandom_range(64, 1)), 49, 49, 50);
    random_phase(7'($urandom_range(20, 1)), 0, 0, 50);

    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    $display("run covered %0d points and %0d curve words over resolutions 0 to 127,",
             sent, seen_words);
    $display("with restarts, saturation, random idling and a long output hold-off");
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #4000000;
    $display("timeout with %0d words outstanding", pending);
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
